// ----- design/dds_pkg.sv -----
// ----------------------------------------------------------------------------
// dds_pkg: shared definitions for the decimal digit square root
// Place counts, field widths, power-of-ten helper, microcode encoding and
// the control program of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

	// decimal places of the root
	localparam int INT_PLACES  = 5;
	localparam int FRAC_PLACES = 4;
	localparam int PLACES      = INT_PLACES + FRAC_PLACES;

	// field and datapath widths
	localparam int RAD_W   = 60;
	localparam int ROOT_W  = 30;
	localparam int ACC_W   = RAD_W + 2;
	localparam int MUL_W   = 2 * ROOT_W;
	localparam int PLACE_W = $clog2(PLACES);
	localparam int DIG_W   = 4;
	localparam int PC_W    = 3;

	// power of ten, only called with constant arguments
	function automatic logic [63:0] pow10(input int unsigned n);
		logic [63:0] v;
		v = 64'd1;
		for (int unsigned i = 0; i < n; i++) begin
			v = v * 64'd10;
		end
		return v;
	endfunction

	localparam logic [63:0]       SAT_LIMIT  = pow10(2 * PLACES);
	localparam logic [ROOT_W-1:0] ROOT_NINES = ROOT_W'(pow10(PLACES) - 64'd1);
	localparam logic [DIG_W-1:0]  DIG_MAX    = DIG_W'(9);

	// datapath operation of one microcode step
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,   // take a request, clear root
		OP_MUL,    // root times place step
		OP_INC,    // first trial increment
		OP_TRIAL,  // try next digit, commit when it fits
		OP_NEXT,   // advance to the next lower place
		OP_EMIT    // write the output register
	} op_t;

	// jump condition; when true the step counter loads the target
	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_IN,
		COND_SAT,
		COND_FIT,
		COND_NOT_LAST,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} uword_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic in_valid;
		logic sat;
		logic fit;
		logic last;
		logic out_busy;
	} dds_status_t;

	// step addresses
	localparam logic [PC_W-1:0] PC_LOAD  = 3'd0;
	localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
	localparam logic [PC_W-1:0] PC_MUL   = 3'd2;
	localparam logic [PC_W-1:0] PC_INC   = 3'd3;
	localparam logic [PC_W-1:0] PC_TRIAL = 3'd4;
	localparam logic [PC_W-1:0] PC_NEXT  = 3'd5;
	localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;
	localparam logic [PC_W-1:0] PC_RET   = 3'd7;

	// control program
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			PC_LOAD:  w = '{op: OP_LOAD,  cond: COND_NO_IN,    target: PC_LOAD};
			PC_CHECK: w = '{op: OP_NOP,   cond: COND_SAT,      target: PC_EMIT};
			PC_MUL:   w = '{op: OP_MUL,   cond: COND_NONE,     target: PC_LOAD};
			PC_INC:   w = '{op: OP_INC,   cond: COND_NONE,     target: PC_LOAD};
			PC_TRIAL: w = '{op: OP_TRIAL, cond: COND_FIT,      target: PC_TRIAL};
			PC_NEXT:  w = '{op: OP_NEXT,  cond: COND_NOT_LAST, target: PC_MUL};
			PC_EMIT:  w = '{op: OP_EMIT,  cond: COND_OUT_BUSY, target: PC_EMIT};
			PC_RET:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: PC_LOAD};
			default:  w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: PC_LOAD};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/dds_seq.sv -----
// ----------------------------------------------------------------------------
// dds_seq: microcode sequencer
// Step counter over the control program; conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dds_pkg::dds_status_t status,
	output dds_pkg::uword_t           uword
);

	logic [dds_pkg::PC_W-1:0] pc_q;
	logic                     jump;

	assign uword = dds_pkg::ucode(pc_q);

	// jump condition select
	always_comb begin
		unique case (uword.cond)
			dds_pkg::COND_NONE:     jump = 1'b0;
			dds_pkg::COND_ALWAYS:   jump = 1'b1;
			dds_pkg::COND_NO_IN:    jump = !status.in_valid;
			dds_pkg::COND_SAT:      jump = status.sat;
			dds_pkg::COND_FIT:      jump = status.fit;
			dds_pkg::COND_NOT_LAST: jump = !status.last;
			dds_pkg::COND_OUT_BUSY: jump = status.out_busy;
			default:                jump = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= dds_pkg::PC_LOAD;
		end else if (jump) begin
			pc_q <= uword.target;
		end else begin
			pc_q <= pc_q + dds_pkg::PC_W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- design/decimal_digit_square_root.sv -----
// ----------------------------------------------------------------------------
// decimal_digit_square_root: truncated square root, one decimal place at a time
// Microcoded sequencer over a datapath with one multiplier and one subtractor.
// ----------------------------------------------------------------------------
// Flow: an accepted request goes to a check step; a saturated radicand goes
// straight to the emit step. Otherwise each of the nine places, highest first,
// runs a multiply step, a setup step, a trial step for each digit value up to
// the first that does not fit, and an advance step; then the emit step writes
// the result. A new request is taken only after the emit step. The output
// register lets the next request start while a result waits.
// Reset: asynchronous, active low; returns to idle with no result pending.
`default_nettype none

module decimal_digit_square_root (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [dds_pkg::RAD_W-1:0]   radicand,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [dds_pkg::ROOT_W-1:0]  root,
	output logic                             saturated
);

	localparam int TBL_N = 2 ** dds_pkg::PLACE_W;

	dds_pkg::uword_t      uword;
	dds_pkg::dds_status_t status;

	logic [dds_pkg::RAD_W-1:0]   rem_q;
	logic [dds_pkg::ROOT_W-1:0]  acc_root_q;
	logic                        sat_q;
	logic [dds_pkg::PLACE_W-1:0] place_q;
	logic [dds_pkg::DIG_W-1:0]   dig_q;
	logic [dds_pkg::MUL_W-1:0]   prod_q;
	logic [dds_pkg::ACC_W-1:0]   inc_q;
	logic [dds_pkg::ROOT_W-1:0]  root_q;
	logic                        saturated_q;
	logic                        out_valid_q;

	logic [dds_pkg::ROOT_W-1:0]  step_tbl [TBL_N];
	logic [dds_pkg::ACC_W-1:0]   sq_tbl   [TBL_N];
	logic [dds_pkg::ACC_W-1:0]   sq2_tbl  [TBL_N];

	logic [dds_pkg::ROOT_W-1:0]  step_cur;
	logic [dds_pkg::MUL_W-1:0]   mul_res;
	logic                        accept;
	logic                        fit;
	logic                        out_busy;

	// place step s, s squared and twice s squared, highest place first
	for (genvar k = 0; k < TBL_N; k++) begin : g_tbl
		localparam logic [63:0] S = (k < dds_pkg::PLACES) ?
			dds_pkg::pow10((k < dds_pkg::PLACES) ? (dds_pkg::PLACES - 1 - k) : 0) : 64'd0;
		assign step_tbl[k] = dds_pkg::ROOT_W'(S);
		assign sq_tbl[k]   = dds_pkg::ACC_W'(S * S);
		assign sq2_tbl[k]  = dds_pkg::ACC_W'((S * S) << 1);
	end

	assign step_cur = step_tbl[place_q];
	assign mul_res  = dds_pkg::MUL_W'(acc_root_q) * dds_pkg::MUL_W'(step_cur);

	// handshake and flags
	assign in_ready = (uword.op == dds_pkg::OP_LOAD);
	assign accept   = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;
	assign fit      = (dig_q != dds_pkg::DIG_MAX) &&
	                  (inc_q <= dds_pkg::ACC_W'(rem_q));

	assign status.in_valid = in_valid;
	assign status.sat      = sat_q;
	assign status.fit      = fit;
	assign status.last     = (place_q == dds_pkg::PLACE_W'(dds_pkg::PLACES - 1));
	assign status.out_busy = out_busy;

	dds_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uword  (uword)
	);

	// datapath: remainder, root, trial increment
	always_ff @(posedge clk) begin
		unique case (uword.op)
			dds_pkg::OP_LOAD: begin
				if (accept) begin
					rem_q      <= radicand;
					acc_root_q <= '0;
					sat_q      <= ({4'd0, radicand} >= dds_pkg::SAT_LIMIT);
				end
			end
			dds_pkg::OP_MUL: begin
				prod_q <= mul_res;
			end
			dds_pkg::OP_INC: begin
				// first increment: 2*root*s + s*s
				inc_q <= (dds_pkg::ACC_W'(prod_q) << 1) + sq_tbl[place_q];
				dig_q <= '0;
			end
			dds_pkg::OP_TRIAL: begin
				if (fit) begin
					rem_q      <= rem_q - dds_pkg::RAD_W'(inc_q);
					inc_q      <= inc_q + sq2_tbl[place_q];
					acc_root_q <= acc_root_q + step_cur;
					dig_q      <= dig_q + dds_pkg::DIG_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// place counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_q <= '0;
		end else if (accept) begin
			place_q <= '0;
		end else if (uword.op == dds_pkg::OP_NEXT && !status.last) begin
			place_q <= place_q + dds_pkg::PLACE_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uword.op == dds_pkg::OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uword.op == dds_pkg::OP_EMIT && !out_busy) begin
			root_q      <= sat_q ? dds_pkg::ROOT_NINES : acc_root_q;
			saturated_q <= sat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign saturated = saturated_q;

endmodule

`default_nettype wire
